FILE: src/hms_pkg.sv
// hms_pkg: shared widths, register map, datapath command codes and
// control/status structs for the homography mlesac scoring unit
// no dependencies
package hms_pkg;

    localparam int COORD_W = 32;
    localparam int COEF_W  = 32;
    localparam int THR_W   = 32;
    localparam int SLOT_W  = 16;
    localparam int CNT_W   = 17;
    localparam int SCORE_W = 64;

    localparam int MAX_MATCHES_DEF = 65536;

    // apb register map
    localparam int CFG_DW = 64;
    localparam int CFG_AW = 6;
    localparam logic [2:0] REG_PAIR_A = 3'd0;
    localparam logic [2:0] REG_PAIR_B = 3'd1;
    localparam logic [2:0] REG_PAIR_C = 3'd2;
    localparam logic [2:0] REG_PAIR_D = 3'd3;
    localparam logic [2:0] REG_BR     = 3'd4;
    localparam logic [2:0] REG_THR    = 3'd5;

    localparam logic [63:0] PAIR_A_RST = 64'h0100_0000_0000_0000;
    localparam logic [63:0] PAIR_B_RST = 64'h0;
    localparam logic [63:0] PAIR_C_RST = 64'h0100_0000_0000_0000;
    localparam logic [63:0] PAIR_D_RST = 64'h0;
    localparam logic [31:0] BR_RST     = 32'h0100_0000;
    localparam logic [31:0] THR_RST    = 32'h0004_0000;

    // datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 116;
    localparam int E_W    = 42;
    localparam int D_W    = 56;
    localparam int S_W    = 40;
    localparam int ERR_W  = 113;
    localparam int SSQ_W  = 80;
    localparam int BND_W  = 112;
    localparam int STEP_W = 6;

    // multiplier operand selects
    localparam logic [4:0] MS_NONE  = 5'd0;
    localparam logic [4:0] MS_H00_X = 5'd1;
    localparam logic [4:0] MS_H01_Y = 5'd2;
    localparam logic [4:0] MS_H02_1 = 5'd3;
    localparam logic [4:0] MS_H10_X = 5'd4;
    localparam logic [4:0] MS_H11_Y = 5'd5;
    localparam logic [4:0] MS_H12_1 = 5'd6;
    localparam logic [4:0] MS_H20_X = 5'd7;
    localparam logic [4:0] MS_H21_Y = 5'd8;
    localparam logic [4:0] MS_H22_1 = 5'd9;
    localparam logic [4:0] MS_U_EH  = 5'd10;
    localparam logic [4:0] MS_U_EL  = 5'd11;
    localparam logic [4:0] MS_V_EH  = 5'd12;
    localparam logic [4:0] MS_V_EL  = 5'd13;
    localparam logic [4:0] MS_D0_LL = 5'd14;
    localparam logic [4:0] MS_D0_LH = 5'd15;
    localparam logic [4:0] MS_D0_HH = 5'd16;
    localparam logic [4:0] MS_D1_LL = 5'd17;
    localparam logic [4:0] MS_D1_LH = 5'd18;
    localparam logic [4:0] MS_D1_HH = 5'd19;
    localparam logic [4:0] MS_S_LL  = 5'd20;
    localparam logic [4:0] MS_S_LH  = 5'd21;
    localparam logic [4:0] MS_S_HH  = 5'd22;
    localparam logic [4:0] MS_SQ0_T = 5'd23;
    localparam logic [4:0] MS_SQ1_T = 5'd24;
    localparam logic [4:0] MS_SQ2_T = 5'd25;

    // accumulator operations and product shifts
    localparam logic [1:0] AC_NONE = 2'd0;
    localparam logic [1:0] AC_CLR  = 2'd1;
    localparam logic [1:0] AC_ADD  = 2'd2;

    localparam logic [2:0] SH_0  = 3'd0;
    localparam logic [2:0] SH_16 = 3'd1;
    localparam logic [2:0] SH_21 = 3'd2;
    localparam logic [2:0] SH_29 = 3'd3;
    localparam logic [2:0] SH_32 = 3'd4;
    localparam logic [2:0] SH_40 = 3'd5;
    localparam logic [2:0] SH_56 = 3'd6;
    localparam logic [2:0] SH_64 = 3'd7;

    // accumulator write-back targets
    localparam logic [3:0] WB_NONE = 4'd0;
    localparam logic [3:0] WB_E0   = 4'd1;
    localparam logic [3:0] WB_E1   = 4'd2;
    localparam logic [3:0] WB_E2   = 4'd3;
    localparam logic [3:0] WB_D0   = 4'd4;
    localparam logic [3:0] WB_D1   = 4'd5;
    localparam logic [3:0] WB_ERR  = 4'd6;
    localparam logic [3:0] WB_SSQ  = 4'd7;
    localparam logic [3:0] WB_BND  = 4'd8;

    typedef struct packed {
        logic       load;
        logic [4:0] mul_sel;
        logic [1:0] acc_op;
        logic [2:0] acc_sh;
        logic [3:0] wb;
        logic       div_step;
        logic       upd;
        logic       inl;
    } t_cmd;

    typedef struct packed {
        logic e2_zero;
        logic err_big;
        logic in_bound;
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [COEF_W-1:0] h00;
        logic [COEF_W-1:0] h01;
        logic [COEF_W-1:0] h02;
        logic [COEF_W-1:0] h10;
        logic [COEF_W-1:0] h11;
        logic [COEF_W-1:0] h12;
        logic [COEF_W-1:0] h20;
        logic [COEF_W-1:0] h21;
        logic [COEF_W-1:0] h22;
        logic [THR_W-1:0]  thr;
    } t_coef;

endpackage

FILE: src/hms_if.sv
// hms_if: valid/ready channel interfaces for correspondences and results
// depends on hms_pkg
interface hms_match_if import hms_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic                      last_match;

    modport source (output valid, first_x, first_y, second_x, second_y, last_match,
                    input ready);
    modport sink (input valid, first_x, first_y, second_x, second_y, last_match,
                  output ready);
endinterface

interface hms_result_if import hms_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               is_inlier;
    logic [SLOT_W-1:0]  inlier_slot;
    logic [THR_W-1:0]   clipped_error;
    logic [SCORE_W-1:0] running_score;
    logic [CNT_W-1:0]   inliers_so_far;
    logic               last_result;

    modport source (output valid, is_inlier, inlier_slot, clipped_error, running_score,
                    inliers_so_far, last_result, input ready);
    modport sink (input valid, is_inlier, inlier_slot, clipped_error, running_score,
                  inliers_so_far, last_result, output ready);
endinterface

FILE: src/hms_cfg.sv
// hms_cfg: apb register file holding the homography and error threshold
// depends on hms_pkg
module hms_cfg import hms_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_coef             o_coef
);
    logic [63:0]       r_pair_a, r_pair_b, r_pair_c, r_pair_d;
    logic [COEF_W-1:0] r_br;
    logic [THR_W-1:0]  r_thr;
    logic [2:0]        w_idx;

    assign w_idx  = paddr[5:3];
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_a <= PAIR_A_RST;
            r_pair_b <= PAIR_B_RST;
            r_pair_c <= PAIR_C_RST;
            r_pair_d <= PAIR_D_RST;
            r_br     <= BR_RST;
            r_thr    <= THR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_PAIR_A: r_pair_a <= pwdata;
                REG_PAIR_B: r_pair_b <= pwdata;
                REG_PAIR_C: r_pair_c <= pwdata;
                REG_PAIR_D: r_pair_d <= pwdata;
                REG_BR:     r_br     <= pwdata[COEF_W-1:0];
                REG_THR:    r_thr    <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PAIR_A: prdata = r_pair_a;
            REG_PAIR_B: prdata = r_pair_b;
            REG_PAIR_C: prdata = r_pair_c;
            REG_PAIR_D: prdata = r_pair_d;
            REG_BR:     prdata = {32'd0, r_br};
            REG_THR:    prdata = {32'd0, r_thr};
            default:    prdata = '0;
        endcase
    end

    assign o_coef.h00 = r_pair_a[63:32];
    assign o_coef.h01 = r_pair_a[31:0];
    assign o_coef.h02 = r_pair_b[63:32];
    assign o_coef.h10 = r_pair_b[31:0];
    assign o_coef.h11 = r_pair_c[63:32];
    assign o_coef.h12 = r_pair_c[31:0];
    assign o_coef.h20 = r_pair_d[63:32];
    assign o_coef.h21 = r_pair_d[31:0];
    assign o_coef.h22 = r_br;
    assign o_coef.thr = r_thr;

endmodule

FILE: src/hms_ctrl.sv
// hms_ctrl: sequencer issuing multiply, accumulate, write-back and divide commands
// depends on hms_pkg
module hms_ctrl import hms_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam logic [STEP_W-1:0] ST_CHK_E2  = 6'd15;
    localparam logic [STEP_W-1:0] ST_CHK_ERR = 6'd31;
    localparam logic [STEP_W-1:0] ST_CHK_BND = 6'd41;
    localparam logic [STEP_W-1:0] DIV_LAST   = 6'd31;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_inl, n_inl;
    t_cmd              w_mc;

    function automatic t_cmd mc(input logic [4:0] ms, input logic [1:0] ao,
                                input logic [2:0] sh, input logic [3:0] wb);
        t_cmd c;
        c         = '0;
        c.mul_sel = ms;
        c.acc_op  = ao;
        c.acc_sh  = sh;
        c.wb      = wb;
        return c;
    endfunction

    always_comb begin
        unique case (r_step)
            6'd0:    w_mc = mc(MS_H00_X, AC_CLR, SH_0, WB_NONE);
            6'd1:    w_mc = mc(MS_H01_Y, AC_ADD, SH_0, WB_NONE);
            6'd2:    w_mc = mc(MS_H02_1, AC_ADD, SH_0, WB_NONE);
            6'd4:    w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_E0);
            6'd5:    w_mc = mc(MS_H10_X, AC_CLR, SH_0, WB_NONE);
            6'd6:    w_mc = mc(MS_H11_Y, AC_ADD, SH_0, WB_NONE);
            6'd7:    w_mc = mc(MS_H12_1, AC_ADD, SH_0, WB_NONE);
            6'd9:    w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_E1);
            6'd10:   w_mc = mc(MS_H20_X, AC_CLR, SH_0, WB_NONE);
            6'd11:   w_mc = mc(MS_H21_Y, AC_ADD, SH_0, WB_NONE);
            6'd12:   w_mc = mc(MS_H22_1, AC_ADD, SH_0, WB_NONE);
            6'd14:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_E2);
            6'd15:   w_mc = mc(MS_U_EH, AC_CLR, SH_16, WB_NONE);
            6'd16:   w_mc = mc(MS_U_EL, AC_ADD, SH_0, WB_NONE);
            6'd18:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_D0);
            6'd19:   w_mc = mc(MS_V_EH, AC_CLR, SH_16, WB_NONE);
            6'd20:   w_mc = mc(MS_V_EL, AC_ADD, SH_0, WB_NONE);
            6'd22:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_D1);
            6'd23:   w_mc = mc(MS_D0_LL, AC_CLR, SH_0, WB_NONE);
            6'd24:   w_mc = mc(MS_D0_LH, AC_ADD, SH_29, WB_NONE);
            6'd25:   w_mc = mc(MS_D0_HH, AC_ADD, SH_56, WB_NONE);
            6'd26:   w_mc = mc(MS_D1_LL, AC_ADD, SH_0, WB_NONE);
            6'd27:   w_mc = mc(MS_D1_LH, AC_ADD, SH_29, WB_NONE);
            6'd28:   w_mc = mc(MS_D1_HH, AC_ADD, SH_56, WB_NONE);
            6'd30:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_ERR);
            6'd31:   w_mc = mc(MS_S_LL, AC_CLR, SH_0, WB_NONE);
            6'd32:   w_mc = mc(MS_S_LH, AC_ADD, SH_21, WB_NONE);
            6'd33:   w_mc = mc(MS_S_HH, AC_ADD, SH_40, WB_NONE);
            6'd35:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_SSQ);
            6'd36:   w_mc = mc(MS_SQ0_T, AC_CLR, SH_0, WB_NONE);
            6'd37:   w_mc = mc(MS_SQ1_T, AC_ADD, SH_32, WB_NONE);
            6'd38:   w_mc = mc(MS_SQ2_T, AC_ADD, SH_64, WB_NONE);
            6'd40:   w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_BND);
            default: w_mc = mc(MS_NONE, AC_NONE, SH_0, WB_NONE);
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        n_step     = r_step;
        n_inl      = r_inl;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_RUN;
                    n_step  = '0;
                end
            end
            S_RUN: begin
                o_cmd = w_mc;
                if (r_step == ST_CHK_E2 && i_sts.e2_zero) begin
                    n_state = S_UPD;
                    n_inl   = 1'b0;
                end else if (r_step == ST_CHK_ERR && i_sts.err_big) begin
                    n_state = S_UPD;
                    n_inl   = 1'b0;
                end else if (r_step == ST_CHK_BND) begin
                    n_step = '0;
                    if (i_sts.in_bound) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_UPD;
                        n_inl   = 1'b0;
                    end
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = S_UPD;
                    n_inl   = 1'b1;
                end else begin
                    n_step = r_step + 6'd1;
                end
            end
            S_UPD: begin
                o_cmd.upd = i_sts.out_free;
                o_cmd.inl = r_inl;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_inl   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_inl   <= n_inl;
        end
    end

endmodule

FILE: src/hms_dp.sv
// hms_dp: shared multiplier, wide accumulator, restoring divider, score and count
// depends on hms_pkg; driven by hms_ctrl commands
module hms_dp import hms_pkg::*; #(
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  t_coef                     i_coef,
    input  logic signed [COORD_W-1:0] i_first_x,
    input  logic signed [COORD_W-1:0] i_first_y,
    input  logic signed [COORD_W-1:0] i_second_x,
    input  logic signed [COORD_W-1:0] i_second_y,
    input  logic                      i_last_match,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic                      o_is_inlier,
    output logic [SLOT_W-1:0]         o_inlier_slot,
    output logic [THR_W-1:0]          o_clipped_error,
    output logic [SCORE_W-1:0]        o_running_score,
    output logic [CNT_W-1:0]          o_inliers_so_far,
    output logic                      o_last_result
);
    localparam int CAP_I = (MAX_MATCHES < 131071) ? MAX_MATCHES : 131071;
    localparam logic [CNT_W-1:0]        CAP     = CNT_W'(CAP_I);
    localparam logic [CNT_W-1:0]        SLOT_MX = CNT_W'(65535);
    localparam logic signed [MUL_W-1:0] ONE_Q16 = MUL_W'(65536);

    logic signed [COORD_W-1:0] r_x, r_y, r_u, r_v;
    logic                      r_last;
    logic signed [PROD_W-1:0]  r_prod;
    logic [1:0]                r_aop;
    logic [2:0]                r_ash;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [E_W-1:0]     r_e0, r_e1, r_e2;
    logic [S_W-1:0]            r_s;
    logic [D_W-1:0]            r_d0, r_d1;
    logic [ERR_W-1:0]          r_err;
    logic [SSQ_W-1:0]          r_ssq;
    logic [BND_W-1:0]          r_bound, r_rem, r_dv;
    logic [THR_W-1:0]          r_q;
    logic [SCORE_W-1:0]        r_score;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_ovalid;

    logic signed [MUL_W-1:0]   w_ma, w_mb;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [ACC_W-1:0]   w_pext, w_psh;
    logic signed [E_W-1:0]     w_e;
    logic signed [57:0]        w_hf, w_eo, w_d;
    logic [D_W-1:0]            w_dmag;
    logic                      w_ge;
    logic [THR_W-1:0]          w_clip;
    logic [SCORE_W:0]          w_sum;
    logic [SCORE_W-1:0]        w_score;
    logic [SLOT_W-1:0]         w_slot;
    logic [CNT_W-1:0]          w_cnt;

    // multiplier operand select
    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_H00_X: begin w_ma = {i_coef.h00[31], i_coef.h00}; w_mb = {r_x[31], r_x}; end
            MS_H01_Y: begin w_ma = {i_coef.h01[31], i_coef.h01}; w_mb = {r_y[31], r_y}; end
            MS_H02_1: begin w_ma = {i_coef.h02[31], i_coef.h02}; w_mb = ONE_Q16; end
            MS_H10_X: begin w_ma = {i_coef.h10[31], i_coef.h10}; w_mb = {r_x[31], r_x}; end
            MS_H11_Y: begin w_ma = {i_coef.h11[31], i_coef.h11}; w_mb = {r_y[31], r_y}; end
            MS_H12_1: begin w_ma = {i_coef.h12[31], i_coef.h12}; w_mb = ONE_Q16; end
            MS_H20_X: begin w_ma = {i_coef.h20[31], i_coef.h20}; w_mb = {r_x[31], r_x}; end
            MS_H21_Y: begin w_ma = {i_coef.h21[31], i_coef.h21}; w_mb = {r_y[31], r_y}; end
            MS_H22_1: begin w_ma = {i_coef.h22[31], i_coef.h22}; w_mb = ONE_Q16; end
            MS_U_EH:  begin w_ma = {r_u[31], r_u}; w_mb = {{7{r_e2[41]}}, r_e2[41:16]}; end
            MS_U_EL:  begin w_ma = {r_u[31], r_u}; w_mb = {17'd0, r_e2[15:0]}; end
            MS_V_EH:  begin w_ma = {r_v[31], r_v}; w_mb = {{7{r_e2[41]}}, r_e2[41:16]}; end
            MS_V_EL:  begin w_ma = {r_v[31], r_v}; w_mb = {17'd0, r_e2[15:0]}; end
            MS_D0_LL: begin w_ma = {5'd0, r_d0[27:0]};  w_mb = {5'd0, r_d0[27:0]}; end
            MS_D0_LH: begin w_ma = {5'd0, r_d0[27:0]};  w_mb = {5'd0, r_d0[55:28]}; end
            MS_D0_HH: begin w_ma = {5'd0, r_d0[55:28]}; w_mb = {5'd0, r_d0[55:28]}; end
            MS_D1_LL: begin w_ma = {5'd0, r_d1[27:0]};  w_mb = {5'd0, r_d1[27:0]}; end
            MS_D1_LH: begin w_ma = {5'd0, r_d1[27:0]};  w_mb = {5'd0, r_d1[55:28]}; end
            MS_D1_HH: begin w_ma = {5'd0, r_d1[55:28]}; w_mb = {5'd0, r_d1[55:28]}; end
            MS_S_LL:  begin w_ma = {13'd0, r_s[19:0]};  w_mb = {13'd0, r_s[19:0]}; end
            MS_S_LH:  begin w_ma = {13'd0, r_s[19:0]};  w_mb = {13'd0, r_s[39:20]}; end
            MS_S_HH:  begin w_ma = {13'd0, r_s[39:20]}; w_mb = {13'd0, r_s[39:20]}; end
            MS_SQ0_T: begin w_ma = {1'b0, r_ssq[31:0]};  w_mb = {1'b0, i_coef.thr}; end
            MS_SQ1_T: begin w_ma = {1'b0, r_ssq[63:32]}; w_mb = {1'b0, i_coef.thr}; end
            MS_SQ2_T: begin w_ma = {17'd0, r_ssq[79:64]}; w_mb = {1'b0, i_coef.thr}; end
            default:  begin w_ma = '0; w_mb = '0; end
        endcase
    end

    assign w_prod = w_ma * w_mb;
    assign w_pext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_comb begin
        unique case (r_ash)
            SH_0:    w_psh = w_pext;
            SH_16:   w_psh = w_pext <<< 16;
            SH_21:   w_psh = w_pext <<< 21;
            SH_29:   w_psh = w_pext <<< 29;
            SH_32:   w_psh = w_pext <<< 32;
            SH_40:   w_psh = w_pext <<< 40;
            SH_56:   w_psh = w_pext <<< 56;
            SH_64:   w_psh = w_pext <<< 64;
            default: w_psh = w_pext;
        endcase
    end

    // write-back helpers: projection floor and homogeneous error magnitude
    assign w_e  = r_acc[24+E_W-1:24];
    assign w_hf = r_acc[73:16];
    assign w_eo = (i_cmd.wb == WB_D0) ? {{16{r_e0[41]}}, r_e0} : {{16{r_e1[41]}}, r_e1};
    assign w_d  = w_hf - w_eo;
    assign w_dmag = w_d[57] ? D_W'(-w_d) : w_d[D_W-1:0];

    assign w_ge = (r_dv <= r_rem);

    // score and count update
    assign w_clip  = i_cmd.inl ? r_q : i_coef.thr;
    assign w_sum   = {1'b0, r_score} + {17'd0, w_clip, 16'd0};
    assign w_score = w_sum[SCORE_W] ? '1 : w_sum[SCORE_W-1:0];
    assign w_slot  = (r_cnt < SLOT_MX) ? r_cnt[SLOT_W-1:0] : '1;
    assign w_cnt   = (i_cmd.inl && (r_cnt < CAP)) ? r_cnt + 17'd1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x    <= i_first_x;
            r_y    <= i_first_y;
            r_u    <= i_second_x;
            r_v    <= i_second_y;
            r_last <= i_last_match;
        end
        r_prod <= w_prod;
        if (r_aop == AC_CLR) begin
            r_acc <= w_psh;
        end else if (r_aop == AC_ADD) begin
            r_acc <= r_acc + w_psh;
        end
        unique case (i_cmd.wb)
            WB_E0: r_e0 <= w_e;
            WB_E1: r_e1 <= w_e;
            WB_E2: begin
                r_e2 <= w_e;
                r_s  <= w_e[E_W-1] ? S_W'(-w_e) : w_e[S_W-1:0];
            end
            WB_D0:  r_d0  <= w_dmag;
            WB_D1:  r_d1  <= w_dmag;
            WB_ERR: r_err <= r_acc[ERR_W-1:0];
            WB_SSQ: r_ssq <= r_acc[SSQ_W-1:0];
            WB_BND: begin
                r_bound <= r_acc[BND_W-1:0];
                r_rem   <= {r_err[95:0], 16'd0};
                r_dv    <= {1'b0, r_ssq, 31'd0};
                r_q     <= '0;
            end
            default: ;
        endcase
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dv;
            end
            r_q  <= {r_q[THR_W-2:0], w_ge};
            r_dv <= r_dv >> 1;
        end
        if (i_cmd.upd) begin
            o_is_inlier      <= i_cmd.inl;
            o_inlier_slot    <= i_cmd.inl ? w_slot : '0;
            o_clipped_error  <= w_clip;
            o_running_score  <= w_score;
            o_inliers_so_far <= w_cnt;
            o_last_result    <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aop    <= AC_NONE;
            r_ash    <= SH_0;
            r_score  <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_aop <= i_cmd.acc_op;
            r_ash <= i_cmd.acc_sh;
            if (i_cmd.upd) begin
                r_ovalid <= 1'b1;
                r_score  <= r_last ? '0 : w_score;
                r_cnt    <= r_last ? '0 : w_cnt;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_sts.e2_zero  = (r_e2 == '0);
    assign o_sts.err_big  = |r_err[ERR_W-1:96];
    assign o_sts.in_bound = (r_rem <= r_bound);
    assign o_sts.out_free = !r_ovalid || i_out_ready;

endmodule

FILE: src/homography_mlesac_score_and_inliers_unit.sv
// homography_mlesac_score_and_inliers_unit: top level, apb registers, sequencer, datapath
// depends on hms_pkg, hms_if, hms_cfg, hms_ctrl, hms_dp
//
//   channel    dir   kind        transfer
//   i_match    in    valid/ready one correspondence, last_match marks end of set
//   o_result   out   valid/ready one scored result per correspondence
//   apb        in    psel/penable one register write or read, pready always high
//
// an inlier result passes through the single shared 33x33 multiplier (25 products) and the
// one-bit-per-cycle restoring divider (32 steps); one correspondence is worked on at a time
// outliers finish early: on zero scale, on a huge error, or above threshold
// synchronous active-low reset clears the sequencer, score and inlier count
// a new correspondence is taken while the previous result waits in the output register
module homography_mlesac_score_and_inliers_unit import hms_pkg::*; #(
    parameter int MAX_MATCHES = MAX_MATCHES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hms_match_if.sink         i_match,
    hms_result_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);
    t_coef w_coef;
    t_cmd  w_cmd;
    t_sts  w_sts;

    hms_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    hms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_match.valid),
        .o_in_ready (i_match.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hms_dp #(
        .MAX_MATCHES (MAX_MATCHES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_coef           (w_coef),
        .i_first_x        (i_match.first_x),
        .i_first_y        (i_match.first_y),
        .i_second_x       (i_match.second_x),
        .i_second_y       (i_match.second_y),
        .i_last_match     (i_match.last_match),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_is_inlier      (o_result.is_inlier),
        .o_inlier_slot    (o_result.inlier_slot),
        .o_clipped_error  (o_result.clipped_error),
        .o_running_score  (o_result.running_score),
        .o_inliers_so_far (o_result.inliers_so_far),
        .o_last_result    (o_result.last_result)
    );

endmodule

FILE: tb/testbench.sv
// testbench for homography_mlesac_score_and_inliers_unit: scoreboard class with
// a bit-true reprojection scorer, apb register writes and valid/ready stimulus
// depends on hms_pkg, hms_if and the unit top level
`timescale 1ns / 100ps

module testbench;
    import hms_pkg::*;

    typedef struct {
        logic               is_inlier;
        logic [SLOT_W-1:0]  inlier_slot;
        logic [THR_W-1:0]   clipped_error;
        logic [SCORE_W-1:0] running_score;
        logic [CNT_W-1:0]   inliers_so_far;
        logic               last_result;
    } t_score;

    class score_board;
        logic signed [31:0] h [9];
        logic [31:0]        thr;
        logic [63:0]        score_acc;
        logic [16:0]        inlier_cnt;
        t_score             pending [$];
        int                 errors;

        function new();
            h = '{32'sh0100_0000, 0, 0, 0, 32'sh0100_0000, 0, 0, 0, 32'sh0100_0000};
            thr = THR_RST;
            score_acc = 0;
            inlier_cnt = 0;
            errors = 0;
        endfunction

        function logic signed [47:0] project(int r, logic signed [31:0] x,
                                             logic signed [31:0] y);
            logic signed [79:0] a0, a1, a2, px, py, s;
            a0 = h[3*r];
            a1 = h[3*r+1];
            a2 = h[3*r+2];
            px = x;
            py = y;
            s = a0 * px + a1 * py + a2 * 80'sd65536;
            return 48'(s >>> 24);
        endfunction

        function logic [127:0] err_mag(logic signed [31:0] s, logic signed [47:0] e2,
                                       logic signed [47:0] e);
            logic signed [79:0] ws, we2, we, d;
            ws = s;
            we2 = e2;
            we = e;
            d = ((ws * we2) >>> 16) - we;
            if (d < 0) d = -d;
            return 128'(d);
        endfunction

        function void note_match(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] u, logic signed [31:0] v, logic last);
            logic signed [47:0] e0, e1, e2;
            logic [127:0] d0, d1, esq, ssq, num, e2m;
            logic         inl;
            logic [31:0]  clip;
            logic [15:0]  slot;
            logic [63:0]  add;
            t_score       t;
            e0 = project(0, x, y);
            e1 = project(1, x, y);
            e2 = project(2, x, y);
            inl = 0;
            clip = thr;
            slot = 0;
            if (e2 != 0) begin
                d0 = err_mag(u, e2, e0);
                d1 = err_mag(v, e2, e1);
                esq = d0 * d0 + d1 * d1;
                e2m = (e2 < 0) ? 128'(-e2) : 128'(e2);
                ssq = e2m * e2m;
                num = esq << 16;
                if (esq[127:96] == 0 && num <= ssq * 128'(thr)) begin
                    inl = 1;
                    clip = 32'(num / ssq);
                end
            end
            if (inl) begin
                slot = (inlier_cnt < 17'd65535) ? inlier_cnt[15:0] : 16'hFFFF;
                if (inlier_cnt < 17'd65536) inlier_cnt++;
            end
            add = {16'd0, clip, 16'd0};
            score_acc = (score_acc > ~add) ? '1 : score_acc + add;
            t.is_inlier = inl;
            t.inlier_slot = slot;
            t.clipped_error = clip;
            t.running_score = score_acc;
            t.inliers_so_far = inlier_cnt;
            t.last_result = last;
            pending.insert(pending.size(), t);
            if (last) begin
                score_acc = 0;
                inlier_cnt = 0;
            end
        endfunction

        function void check_result(t_score a);
            t_score e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result inlier=%0d score=%h", $time,
                         a.is_inlier, a.running_score);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.is_inlier !== e.is_inlier) begin
                $display("%0t is_inlier exp %0d act %0d", $time, e.is_inlier, a.is_inlier);
                errors++;
            end
            if (a.inlier_slot !== e.inlier_slot) begin
                $display("%0t inlier_slot exp %0d act %0d", $time, e.inlier_slot,
                         a.inlier_slot);
                errors++;
            end
            if (a.clipped_error !== e.clipped_error) begin
                $display("%0t clipped_error exp %h act %h", $time, e.clipped_error,
                         a.clipped_error);
                errors++;
            end
            if (a.running_score !== e.running_score) begin
                $display("%0t running_score exp %h act %h", $time, e.running_score,
                         a.running_score);
                errors++;
            end
            if (a.inliers_so_far !== e.inliers_so_far) begin
                $display("%0t inliers_so_far exp %0d act %0d", $time, e.inliers_so_far,
                         a.inliers_so_far);
                errors++;
            end
            if (a.last_result !== e.last_result) begin
                $display("%0t last_result exp %0d act %0d", $time, e.last_result,
                         a.last_result);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              psel = 0;
    logic              penable = 0;
    logic              pwrite = 0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [CFG_DW-1:0] pwdata = '0;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    hms_match_if  m_if ();
    hms_result_if r_if ();

    homography_mlesac_score_and_inliers_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_match(m_if.sink), .o_result(r_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    score_board sb = new();
    int         send_idle = 0;
    int         recv_stall = 0;
    int         hold_off = 0;
    int         cycles = 0;

    always #1 i_clk = ~i_clk;

    initial begin
        m_if.valid = 0;
        m_if.first_x = 0;
        m_if.first_y = 0;
        m_if.second_x = 0;
        m_if.second_y = 0;
        m_if.last_match = 0;
        r_if.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && r_if.valid && r_if.ready)
            sb.check_result('{r_if.is_inlier, r_if.inlier_slot, r_if.clipped_error,
                              r_if.running_score, r_if.inliers_so_far, r_if.last_result});
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            r_if.ready <= 0;
        end else begin
            r_if.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        @(posedge i_clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_PAIR_A: begin sb.h[0] = val[63:32]; sb.h[1] = val[31:0]; end
            REG_PAIR_B: begin sb.h[2] = val[63:32]; sb.h[3] = val[31:0]; end
            REG_PAIR_C: begin sb.h[4] = val[63:32]; sb.h[5] = val[31:0]; end
            REG_PAIR_D: begin sb.h[6] = val[63:32]; sb.h[7] = val[31:0]; end
            REG_BR:     sb.h[8] = val[31:0];
            REG_THR:    sb.thr = val[31:0];
            default: ;
        endcase
    endtask

    task automatic load_homography(logic [31:0] hh [9], logic [31:0] t);
        reg_write(REG_PAIR_A, {hh[0], hh[1]});
        reg_write(REG_PAIR_B, {hh[2], hh[3]});
        reg_write(REG_PAIR_C, {hh[4], hh[5]});
        reg_write(REG_PAIR_D, {hh[6], hh[7]});
        reg_write(REG_BR, {32'd0, hh[8]});
        reg_write(REG_THR, {32'd0, t});
    endtask

    task automatic send_match(logic [31:0] x, logic [31:0] y, logic [31:0] u,
                              logic [31:0] v, logic last);
        while ($urandom_range(99) < send_idle) begin
            m_if.valid <= 0;
            @(posedge i_clk);
        end
        m_if.valid <= 1;
        m_if.first_x <= x;
        m_if.first_y <= y;
        m_if.second_x <= u;
        m_if.second_y <= v;
        m_if.last_match <= last;
        @(posedge i_clk);
        while (!m_if.ready) @(posedge i_clk);
        sb.note_match(x, y, u, v, last);
    endtask

    task automatic drain();
        m_if.valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // random correspondence, mostly near the reprojection of the first point
    task automatic send_random(int spread);
        logic signed [31:0] x, y, u, v;
        logic signed [47:0] e0, e1, e2;
        logic signed [79:0] q;
        int k;
        k = $urandom_range(9);
        x = $signed($urandom) >>> $urandom_range(20, 4);
        y = $signed($urandom) >>> $urandom_range(20, 4);
        u = $urandom;
        v = $urandom;
        if (k == 0) begin
            x = $urandom;
            y = $urandom;
        end else if (k > 1) begin
            e0 = sb.project(0, x, y);
            e1 = sb.project(1, x, y);
            e2 = sb.project(2, x, y);
            if (e2 != 0) begin
                q = (80'(e0) * 80'sd65536) / 80'(e2);
                u = 32'(q) + ($signed($urandom) >>> (31 - spread));
                q = (80'(e1) * 80'sd65536) / 80'(e2);
                v = 32'(q) + ($signed($urandom) >>> (31 - spread));
            end
        end
        send_match(x, y, u, v, $urandom_range(15) == 0);
    endtask

    function automatic logic [31:0] near(logic [31:0] base, int bits);
        return base + 32'($signed($urandom) >>> (31 - bits));
    endfunction

    initial begin
        logic [31:0] hh [9];
        logic [31:0] t;
        int          n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed on reset values: identity, threshold 4.0
        send_match(0, 0, 0, 0, 0);
        send_match(32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0002_0000, 0);
        send_match(32'h0001_0000, 0, 32'h0003_0000, 0, 0);
        send_match(32'h0001_0000, 0, 32'h0003_0001, 0, 0);
        send_match(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_match(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_match(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_match(0, 0, 32'hFFFF_FFFF, 32'h0000_0001, 1);
        send_match(32'hFFFF_FFFF, 32'h0001_8000, 32'hFFFF_0000, 32'h0001_8000, 1);
        drain();

        // vanishing scale: bottom row zero
        hh = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 0};
        load_homography(hh, 32'h0001_0000);
        send_match(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0);
        send_match(0, 0, 0, 0, 0);
        send_match(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1);
        drain();

        // threshold extremes and a huge score
        hh = '{32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000};
        load_homography(hh, 32'hFFFF_FFFF);
        for (n = 0; n < 6; n++) send_match(32'h8000_0000, 32'h8000_0000,
                                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_match(32'h0001_0000, 0, 32'h0101_0000, 0, 1);
        drain();
        reg_write(REG_THR, 64'd0);
        send_match(32'h0001_0000, 0, 32'h0001_0000, 0, 0);
        send_match(32'h0001_0000, 0, 32'h0001_0001, 0, 1);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 46; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 46; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            if (ph == 7) begin
                for (n = 0; n < 9; n++) hh[n] = $urandom;
                t = $urandom;
            end else begin
                hh[0] = near(32'h0100_0000, 21);
                hh[4] = near(32'h0100_0000, 21);
                hh[8] = near(32'h0100_0000, 20);
                hh[1] = near(0, 19);
                hh[3] = near(0, 19);
                hh[2] = near(0, 27);
                hh[5] = near(0, 27);
                hh[6] = near(0, 11);
                hh[7] = near(0, 11);
                if (ph == 3) hh[8] = near(32'hFF00_0000, 20);
                t = (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(32'h0010_0000);
            end
            load_homography(hh, t);
            for (n = 0; n < 55; n++) begin
                if (ph == 2 && n == 10) hold_off = 400;
                if (ph == 4 && n == 30) begin
                    m_if.valid <= 0;
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                send_random($urandom_range(4) == 0 ? 30 : $urandom_range(20, 2));
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
